[hw/rtl/apdc_pkg.sv]
// Shared types and constants for the angular PD controller.
package apdc_pkg;

  localparam int DATA_W    = 32;
  localparam int IV_W      = 24;
  localparam int HALF_W    = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN = 2'd2;

  localparam logic [HALF_W-1:0] HALF_TURN_RESET = 31'd11796480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MOD,
    ST_MUL_T,
    ST_DIV_V,
    ST_MUL_D,
    ST_DONE
  } apdc_state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } apdc_unit_stat_t;

  // One saturated 32-bit term and its clamp mark.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } apdc_term_t;

endpackage

[hw/rtl/apdc_if.sv]
// Valid/ready channel interfaces for the controller's input and result beats.
interface apdc_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       action;
  logic signed [apdc_pkg::DATA_W-1:0]         angle_error;
  logic        [apdc_pkg::IV_W-1:0]           interval_us;
  logic signed [apdc_pkg::DATA_W-1:0]         given_velocity;

  modport source (output valid, action, angle_error, interval_us, given_velocity,
                  input ready);
  modport sink (input valid, action, angle_error, interval_us, given_velocity,
                output ready);
endinterface

interface apdc_out_if #(parameter int CMD_W = 18);
  logic                               valid;
  logic                               ready;
  logic signed [CMD_W-1:0]            command;
  logic signed [apdc_pkg::DATA_W-1:0] p_term;
  logic signed [apdc_pkg::DATA_W-1:0] d_term;
  logic signed [apdc_pkg::DATA_W-1:0] velocity;
  logic                               saturated;

  modport source (output valid, command, p_term, d_term, velocity, saturated,
                  input ready);
  modport sink (input valid, command, p_term, d_term, velocity, saturated,
                output ready);
endinterface

[hw/rtl/apdc_mul.sv]
// Unsigned shift-add multiplier, one multiplier bit per cycle.
module apdc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [AW-1:0]             a,
  input  logic [BW-1:0]             b,
  output logic [AW+BW-1:0]          prod,
  output apdc_pkg::apdc_unit_stat_t stat
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    a_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [AW:0]      sum;

  // Add the multiplicand into the high half, then shift the pair right.
  always_comb begin
    sum     = {1'b0, acc_r[AW+BW-1:BW]} + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt = {sum, acc_r[BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= {{AW{1'b0}}, b};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hw/rtl/apdc_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module apdc_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  output logic [NW-1:0]             quo,
  output logic [DW-1:0]             rem,
  output apdc_pkg::apdc_unit_stat_t stat
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, den_r, rem_nxt;
  logic [DW:0]   shifted, trial;
  logic          ge;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // Bring down the next dividend bit and subtract where it fits.
  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    trial   = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? trial[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quo       = quo_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hw/rtl/angular_pd_controller.sv]
// Angular PD regulator top level: sequencer, serial multiplier and dividers.
//
// One beat in, one beat out. The block takes one item at a time and holds its
// input ready low until the result is staged; a finished result waits in the
// output register, so the next item may be taken while it is still pending.
// All arithmetic runs bit-serially: a shared shift-add multiplier, a 32-bit
// restoring divider for the angle wrap, and a restoring divider of
// VNW = 31 + ceil(log2(TICKS_PER_SECOND+1)) bits for the velocity (51 bits at
// the default). A supplied-velocity item, or the first derived item after
// reset, takes two products. A derived item takes three products and the
// velocity division, plus a run of the wrap divider when the error difference
// lies beyond half a turn and must be folded. The command port is FRAC_BITS+2
// bits wide; the result interface must be built with that width.
module angular_pd_controller #(
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int FRAC_BITS        = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  apdc_in_if.sink                               in_ch,
  apdc_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [apdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apdc_pkg::DATA_W-1:0]           cfg_data
);

  localparam int DW     = apdc_pkg::DATA_W;
  localparam int HW     = apdc_pkg::HALF_W;
  localparam int IW     = apdc_pkg::IV_W;
  localparam int CMD_W  = FRAC_BITS + 2;
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int VNW    = 31 + TPS_W;

  localparam logic [2*DW-1:0]    ROUND_ADD  = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [VNW-1:0]     VQ_POS_MAX = VNW'(32'h7FFF_FFFF);
  localparam logic [VNW-1:0]     VQ_NEG_MAX = VNW'(32'h8000_0000);
  localparam logic signed [32:0] CMD_LIM    = 33'sd1 <<< FRAC_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DW-1:0] kp_r, kd_r;
  logic [HW-1:0] half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      kd_r   <= '0;
      half_r <= apdc_pkg::HALF_TURN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apdc_pkg::CFG_KP_GAIN:   kp_r <= cfg_data;
        apdc_pkg::CFG_KD_GAIN:   kd_r <= cfg_data;
        // A zero half turn acts as one.
        apdc_pkg::CFG_HALF_TURN: half_r <= (cfg_data[HW-1:0] == '0) ? HW'(1)
                                                                   : cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // Turn a product magnitude into the saturated term -(a*b) >> FRAC_BITS,
  // rounded toward minus infinity. neg is the sign of the negated product.
  function automatic apdc_pkg::apdc_term_t term_of(input logic [2*DW-1:0] mag,
                                                   input logic neg);
    logic [2*DW-1:0]      q;
    apdc_pkg::apdc_term_t t;
    if (neg) begin
      q       = (mag + ROUND_ADD) >> FRAC_BITS;
      t.sat   = q > 64'h8000_0000;
      t.value = t.sat ? 32'h8000_0000 : (~q[DW-1:0] + DW'(1));
    end else begin
      q       = mag >> FRAC_BITS;
      t.sat   = q > 64'h7FFF_FFFF;
      t.value = t.sat ? 32'h7FFF_FFFF : q[DW-1:0];
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Sequencer and item state
  // ---------------------------------------------------------------------
  apdc_pkg::apdc_state_t state_r, state_nxt;
  logic                  go_r;

  logic                  in_accept;
  logic                  slot_free;

  logic [DW-1:0]         prev_r;       // previous error
  logic                  has_prev_r;   // a derived step has been seen
  logic [DW-1:0]         err_r;
  logic signed [32:0]    diff_r;       // raw error difference
  logic [IW-1:0]         iv_r;
  logic                  use_div_r;    // velocity comes from the divider
  logic [DW-1:0]         wrapped_r;    // folded difference
  logic [DW-1:0]         vel_r;
  logic [DW-1:0]         p_r, dterm_r;
  logic                  flag_r;

  // Output register
  logic                  out_valid_r;
  logic [CMD_W-1:0]      out_cmd_r;
  logic [DW-1:0]         out_p_r, out_d_r, out_vel_r;
  logic                  out_sat_r;

  // Units
  logic                      mul_start, mod_start, vdiv_start;
  logic [DW-1:0]             mul_a, mul_b;
  logic [2*DW-1:0]           mul_prod;
  apdc_pkg::apdc_unit_stat_t mul_stat, mod_stat, vdiv_stat;
  logic [DW-1:0]             mod_quo, mod_rem, mod_num;
  logic [VNW-1:0]            vdiv_quo;
  logic [IW-1:0]             vdiv_rem;

  // Wrap preparation
  logic signed [33:0]    d_w, h_w, y_w, ym1_w, wrap_w;
  logic                  mod_hi, mod_lo;

  always_comb begin
    d_w    = {diff_r[32], diff_r};
    h_w    = {3'b000, half_r};
    mod_hi = d_w > h_w;
    mod_lo = d_w < -h_w;
    y_w    = mod_hi ? (d_w - h_w) : (-h_w - d_w);
    ym1_w  = y_w - 34'sd1;
    mod_num = ym1_w[DW-1:0];
    // Fold by the remainder of (distance past the half turn - 1) mod a turn.
    wrap_w = mod_hi ? ($signed({2'b00, mod_rem}) + 34'sd1 - h_w)
                    : (h_w - $signed({2'b00, mod_rem}) - 34'sd1);
  end

  // Term and velocity candidates
  apdc_pkg::apdc_term_t p_w, d_term_w;
  logic [DW-1:0]        vel_div_w;
  logic                 vel_sat_w;
  logic signed [32:0]   sum_w;
  logic [CMD_W-1:0]     cmd_w;
  logic                 cmd_clamp_w;

  always_comb begin
    p_w      = term_of(mul_prod, ~(kp_r[DW-1] ^ err_r[DW-1]));
    d_term_w = term_of(mul_prod, ~(kd_r[DW-1] ^ vel_r[DW-1]));

    if (wrapped_r[DW-1]) begin
      vel_sat_w = vdiv_quo > VQ_NEG_MAX;
      vel_div_w = vel_sat_w ? 32'h8000_0000 : (~vdiv_quo[DW-1:0] + DW'(1));
    end else begin
      vel_sat_w = vdiv_quo > VQ_POS_MAX;
      vel_div_w = vel_sat_w ? 32'h7FFF_FFFF : vdiv_quo[DW-1:0];
    end

    // Form the command from the registered terms while the result is staged.
    sum_w = $signed({p_r[DW-1], p_r}) + $signed({dterm_r[DW-1], dterm_r});
    priority if (sum_w > CMD_LIM) begin
      cmd_w       = CMD_LIM[CMD_W-1:0];
      cmd_clamp_w = 1'b1;
    end else if (sum_w < -CMD_LIM) begin
      cmd_w       = CMD_W'(-CMD_LIM);
      cmd_clamp_w = 1'b1;
    end else begin
      cmd_w       = sum_w[CMD_W-1:0];
      cmd_clamp_w = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apdc_pkg::ST_IDLE:  if (in_accept) state_nxt = apdc_pkg::ST_MUL_P;
      apdc_pkg::ST_MUL_P: begin
        if (mul_stat.done) begin
          if (!use_div_r)           state_nxt = apdc_pkg::ST_MUL_D;
          else if (mod_hi || mod_lo) state_nxt = apdc_pkg::ST_MOD;
          else                      state_nxt = apdc_pkg::ST_MUL_T;
        end
      end
      apdc_pkg::ST_MOD:   if (mod_stat.done)  state_nxt = apdc_pkg::ST_MUL_T;
      apdc_pkg::ST_MUL_T: if (mul_stat.done)  state_nxt = apdc_pkg::ST_DIV_V;
      apdc_pkg::ST_DIV_V: if (vdiv_stat.done) state_nxt = apdc_pkg::ST_MUL_D;
      apdc_pkg::ST_MUL_D: if (mul_stat.done)  state_nxt = apdc_pkg::ST_DONE;
      apdc_pkg::ST_DONE:  if (slot_free)      state_nxt = apdc_pkg::ST_IDLE;
      default:                                state_nxt = apdc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, unit launches and operand selection
  always_comb begin
    in_ch.ready = (state_r == apdc_pkg::ST_IDLE);
    in_accept   = in_ch.valid && in_ch.ready;
    slot_free   = !out_valid_r || out_ch.ready;
    mul_start   = go_r && (state_r == apdc_pkg::ST_MUL_P || state_r == apdc_pkg::ST_MUL_T ||
                           state_r == apdc_pkg::ST_MUL_D);
    mod_start   = go_r && (state_r == apdc_pkg::ST_MOD);
    vdiv_start  = go_r && (state_r == apdc_pkg::ST_DIV_V);
    unique case (state_r)
      apdc_pkg::ST_MUL_T: begin
        mul_a = abs32(wrapped_r);
        mul_b = DW'(TICKS_PER_SECOND);
      end
      apdc_pkg::ST_MUL_D: begin
        mul_a = abs32(kd_r);
        mul_b = abs32(vel_r);
      end
      default: begin
        mul_a = abs32(kp_r);
        mul_b = abs32(err_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= apdc_pkg::ST_IDLE;
      go_r       <= 1'b0;
      prev_r     <= '0;
      has_prev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Launch a unit on the first cycle of each arithmetic state.
      go_r    <= (state_nxt != state_r) && (state_nxt != apdc_pkg::ST_IDLE) &&
                 (state_nxt != apdc_pkg::ST_DONE);
      if (in_accept) begin
        prev_r <= in_ch.angle_error;
        if (!in_ch.action) has_prev_r <= 1'b1;
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r     <= in_ch.angle_error;
      diff_r    <= $signed({in_ch.angle_error[DW-1], in_ch.angle_error}) -
                   $signed({prev_r[DW-1], prev_r});
      iv_r      <= (in_ch.interval_us == '0) ? IW'(1) : in_ch.interval_us;
      use_div_r <= !in_ch.action && has_prev_r;
      // First derived step uses zero velocity; supplied mode takes it as given.
      vel_r     <= in_ch.action ? in_ch.given_velocity : '0;
      flag_r    <= 1'b0;
    end
    unique case (state_r)
      apdc_pkg::ST_MUL_P: begin
        if (mul_stat.done) begin
          p_r       <= p_w.value;
          flag_r    <= flag_r | p_w.sat;
          wrapped_r <= diff_r[DW-1:0];
        end
      end
      apdc_pkg::ST_MOD: begin
        if (mod_stat.done) wrapped_r <= wrap_w[DW-1:0];
      end
      apdc_pkg::ST_DIV_V: begin
        if (vdiv_stat.done) begin
          vel_r  <= vel_div_w;
          flag_r <= flag_r | vel_sat_w;
        end
      end
      apdc_pkg::ST_MUL_D: begin
        if (mul_stat.done) begin
          dterm_r <= d_term_w.value;
          flag_r  <= flag_r | d_term_w.sat;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a staged result when the slot is free, drop the
  // beat once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == apdc_pkg::ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == apdc_pkg::ST_DONE && slot_free) begin
      out_cmd_r <= cmd_w;
      out_p_r   <= p_r;
      out_d_r   <= dterm_r;
      out_vel_r <= vel_r;
      out_sat_r <= flag_r | cmd_clamp_w;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.command   = out_cmd_r;
  assign out_ch.p_term    = out_p_r;
  assign out_ch.d_term    = out_d_r;
  assign out_ch.velocity  = out_vel_r;
  assign out_ch.saturated = out_sat_r;

  // ---------------------------------------------------------------------
  // Arithmetic units
  // ---------------------------------------------------------------------
  apdc_mul #(.AW(DW), .BW(DW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  apdc_div #(.NW(DW), .DW(DW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (mod_num),
    .den   ({half_r, 1'b0}),
    .quo   (mod_quo),
    .rem   (mod_rem),
    .stat  (mod_stat)
  );

  apdc_div #(.NW(VNW), .DW(IW)) u_vdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vdiv_start),
    .num   (mul_prod[VNW-1:0]),
    .den   (iv_r),
    .quo   (vdiv_quo),
    .rem   (vdiv_rem),
    .stat  (vdiv_stat)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == apdc_pkg::ST_MUL_P)
    else $error("accepted beat did not start the proportional product");

  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier launched while busy");

  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == apdc_pkg::ST_MUL_P || state_r == apdc_pkg::ST_MUL_T ||
                       state_r == apdc_pkg::ST_MUL_D))
    else $error("multiplier finished outside a product state");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apdc_pkg::ST_DONE && out_valid_r && !out_ch.ready)
      |=> state_r == apdc_pkg::ST_DONE)
    else $error("staged result overwrote a pending beat");

  a_cmd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed({out_cmd_r[CMD_W-1], out_cmd_r}) <= $signed(CMD_LIM[CMD_W:0]) &&
                     $signed({out_cmd_r[CMD_W-1], out_cmd_r}) >= -$signed(CMD_LIM[CMD_W:0])))
    else $error("command beyond clamp limit");

  a_unused_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_stat.done |-> mod_quo <= (mod_num >> 1)) and (vdiv_stat.done |-> vdiv_rem < iv_r))
    else $error("divider results inconsistent with operands");

endmodule

[test/tb_angular_pd_controller.sv]
// Self-checking testbench for the angular PD controller against a local predictor.
`timescale 1ns / 100ps

module tb_angular_pd_controller;

  localparam int     CMD_W      = 18;
  localparam longint TICKS      = 1000000;
  localparam int     FRAC       = 16;
  localparam longint CMD_LIM    = longint'(1) << FRAC;
  localparam longint INT32_HI   = 64'sd2147483647;
  localparam longint INT32_LO   = -64'sd2147483648;
  localparam int     STALL_MAX  = 4000;  // cycles with no beat on either side
  localparam int     DRAIN_WAIT = 250;   // longer than the slowest derived item
  localparam int     PHASE_LEN  = 180;
  localparam int     NUM_PHASES = 8;

  // One control sample as it goes onto the input channel.
  typedef struct {
    logic              action;
    logic signed [31:0] angle_error;
    logic [23:0]       interval_us;
    logic signed [31:0] given_velocity;
  } pd_sample_t;

  // Predicted contents of one result beat.
  typedef struct {
    logic [CMD_W-1:0] command;
    logic [31:0]      p_term;
    logic [31:0]      d_term;
    logic [31:0]      velocity;
    logic             saturated;
  } pd_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [apdc_pkg::CFG_IDX_W-1:0] cfg_index = apdc_pkg::CFG_KP_GAIN;
  logic [apdc_pkg::DATA_W-1:0]    cfg_data = '0;

  apdc_in_if                   in_bus ();
  apdc_out_if #(.CMD_W(CMD_W)) out_bus ();

  angular_pd_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Samples waiting for the driver, and results the controller still owes.
  pd_sample_t pending_samples[$];
  pd_result_t owed_results[$];

  // Shadow of the controller's registers and loop state.
  longint kp_copy = 0;
  longint kd_copy = 0;
  longint half_copy = longint'(apdc_pkg::HALF_TURN_RESET);
  longint last_error = 0;
  bit     primed = 1'b0;

  int     mismatches = 0;
  bit     quiet_gaps = 1'b0;
  int     in_gap = 0;
  int     out_gap = 0;
  int     stall_cycles = 0;
  longint gen_last_err = 0;
  pd_sample_t in_flight;
  pd_result_t want;
  logic [31:0] kp_w, kd_w, ht_w;

  // Gap length between beats: mostly short, now and then long.
  function automatic int rand_gap();
    int pick;
    if (quiet_gaps)
      return 0;
    pick = int'($urandom_range(0, 99));
    if (pick < 55)
      return 0;
    if (pick < 85)
      return int'($urandom_range(1, 3));
    if (pick < 97)
      return int'($urandom_range(4, 16));
    return int'($urandom_range(40, 150));
  endfunction

  function automatic logic [31:0] small_signed(int unsigned span);
    longint v;
    v = longint'($urandom_range(0, span));
    if ($urandom_range(0, 1))
      v = -v;
    return v[31:0];
  endfunction

  function automatic pd_sample_t mk_sample(logic act, logic [31:0] err, logic [23:0] iv,
                                           logic [31:0] vel);
    pd_sample_t s;
    s.action         = act;
    s.angle_error    = err;
    s.interval_us    = iv;
    s.given_velocity = vel;
    return s;
  endfunction

  function automatic longint clip32(longint v, inout bit hit);
    if (v > INT32_HI) begin
      hit = 1'b1;
      return INT32_HI;
    end
    if (v < INT32_LO) begin
      hit = 1'b1;
      return INT32_LO;
    end
    return v;
  endfunction

  // Work out the PD result for one accepted sample and advance the loop state.
  task automatic predict_pd_step(input pd_sample_t s);
    longint err, vel, diff, iv, turn, k, p, d, cmd;
    bit hit;
    pd_result_t r;
    hit = 1'b0;
    err = longint'(s.angle_error);
    if (s.action == 1'b0) begin
      if (!primed) begin
        vel = 0;
        primed = 1'b1;
      end else begin
        iv = longint'(s.interval_us);
        if (iv == 0)
          iv = 1;
        diff = err - last_error;
        turn = 2 * half_copy;
        // Fold by whole turns into the half-turn window.
        if (diff > half_copy) begin
          k = (diff - half_copy + turn - 1) / turn;
          diff = diff - k * turn;
        end else if (diff < -half_copy) begin
          k = (-half_copy - diff + turn - 1) / turn;
          diff = diff + k * turn;
        end
        vel = clip32(diff * TICKS / iv, hit);
      end
    end else begin
      vel = longint'(s.given_velocity);
    end
    // Arithmetic shift floors, as the gain products require.
    p = clip32((-(kp_copy * err)) >>> FRAC, hit);
    d = clip32((-(kd_copy * vel)) >>> FRAC, hit);
    cmd = p + d;
    if (cmd > CMD_LIM) begin
      cmd = CMD_LIM;
      hit = 1'b1;
    end
    if (cmd < -CMD_LIM) begin
      cmd = -CMD_LIM;
      hit = 1'b1;
    end
    last_error = err;
    r.command   = cmd[CMD_W-1:0];
    r.p_term    = p[31:0];
    r.d_term    = d[31:0];
    r.velocity  = vel[31:0];
    r.saturated = hit;
    owed_results.push_back(r);
  endtask

  // Random sample, mostly derived-velocity steps; a third of the errors walk near the last error.
  function automatic pd_sample_t rand_sample();
    pd_sample_t s;
    longint err;
    int pick;
    s.action = ($urandom_range(0, 9) < 3);
    pick = int'($urandom_range(0, 11));
    if (pick < 4)
      err = gen_last_err + longint'($signed(small_signed(1 << 18)));
    else if (pick < 6)
      err = longint'($signed($urandom()));
    else if (pick == 6)
      case ($urandom_range(0, 3))
        0: err = INT32_LO;
        1: err = INT32_HI;
        2: err = 0;
        default: err = -1;
      endcase
    else if (pick < 9)
      err = gen_last_err + (($urandom_range(0, 1) ? 1 : -1) * half_copy *
            $urandom_range(1, 3)) + longint'($signed(small_signed(1 << 12)));
    else
      err = longint'($signed(small_signed(1 << 22)));
    s.angle_error = err[31:0];
    gen_last_err = longint'(s.angle_error);
    pick = int'($urandom_range(0, 9));
    if (pick < 6)
      s.interval_us = 24'($urandom_range(1, 2000));
    else if (pick < 8)
      s.interval_us = 24'($urandom_range(1, 24'hFF_FFFF));
    else if (pick == 8)
      s.interval_us = 24'd1;
    else
      s.interval_us = 24'hFF_FFFF;
    if ($urandom_range(0, 1))
      s.given_velocity = $urandom();
    else
      s.given_velocity = small_signed(1 << 20);
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Write one register at a clock edge and mirror it into the shadow copy.
  task automatic write_reg(input logic [apdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apdc_pkg::CFG_KP_GAIN: kp_copy = longint'($signed(data));
      apdc_pkg::CFG_KD_GAIN: kd_copy = longint'($signed(data));
      apdc_pkg::CFG_HALF_TURN: begin
        half_copy = longint'(data[apdc_pkg::HALF_W-1:0]);
        if (half_copy == 0)
          half_copy = 1;
      end
      default: ;
    endcase
  endtask

  // Hold until every queued sample has been taken and every result has come back.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || in_bus.valid || owed_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Driver: predict each accepted beat, then either hold a gap or load the next sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        predict_pd_step(in_flight);
      // A beat still waiting for ready keeps its payload and valid.
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_flight = pending_samples.pop_front();
          in_bus.action         <= in_flight.action;
          in_bus.angle_error    <= in_flight.angle_error;
          in_bus.interval_us    <= in_flight.interval_us;
          in_bus.given_velocity <= in_flight.given_velocity;
          in_bus.valid          <= 1'b1;
          in_gap = rand_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, then stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual command %h", $time,
                   out_bus.command);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("command", 32'(want.command), 32'($unsigned(out_bus.command)));
          check_field("p_term", want.p_term, out_bus.p_term);
          check_field("d_term", want.d_term, out_bus.d_term);
          check_field("velocity", want.velocity, out_bus.velocity);
          check_field("saturated", 32'(want.saturated), 32'(out_bus.saturated));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        out_gap = rand_gap();
      end
    end
  end

  // Watchdog: drop the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, STALL_MAX);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_bus.valid          = 1'b0;
    in_bus.action         = 1'b0;
    in_bus.angle_error    = '0;
    in_bus.interval_us    = '0;
    in_bus.given_velocity = '0;
    out_bus.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero gains, half turn of 180 degrees.
    // First derived step gives zero velocity; then exact half-turn and folded differences.
    pending_samples.push_back(mk_sample(1'b0, 32'd655360, 24'd1000, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, -32'sd11141120, 24'd1000, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'd11468800, 24'hFF_FFFF, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'd11468800, 24'd0, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, -32'sd327680, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b1, 32'h8000_0000, 24'd5, 32'h7FFF_FFFF));
    pending_samples.push_back(mk_sample(1'b1, 32'h7FFF_FFFF, 24'd5, 32'h8000_0000));
    pending_samples.push_back(mk_sample(1'b0, 32'h8000_0000, 24'd7, 32'd0));
    wait_idle();

    // Unity P gain, small D gain, quarter-turn window.
    write_reg(apdc_pkg::CFG_KP_GAIN, 32'h0001_0000);
    write_reg(apdc_pkg::CFG_KD_GAIN, 32'h0000_0100);
    write_reg(apdc_pkg::CFG_HALF_TURN, 32'd5898240);
    pending_samples.push_back(mk_sample(1'b0, 32'd0, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'd65536, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'd131072, 24'd1000000, 32'd0));
    pending_samples.push_back(mk_sample(1'b1, -32'sd32768, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b1, 32'd1, 24'd1, 32'hFFFF_FFFF));
    pending_samples.push_back(mk_sample(1'b0, 32'd5963776, 24'd3, 32'd0));
    wait_idle();

    // Extreme gains, and a zero half turn that acts as one.
    write_reg(apdc_pkg::CFG_KP_GAIN, 32'h8000_0000);
    write_reg(apdc_pkg::CFG_KD_GAIN, 32'h7FFF_FFFF);
    write_reg(apdc_pkg::CFG_HALF_TURN, 32'h0000_0000);
    pending_samples.push_back(mk_sample(1'b1, 32'h8000_0000, 24'd1, 32'h8000_0000));
    pending_samples.push_back(mk_sample(1'b1, 32'h7FFF_FFFF, 24'd1, 32'h7FFF_FFFF));
    pending_samples.push_back(mk_sample(1'b0, 32'd0, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'd3, 24'd2, 32'd0));
    pending_samples.push_back(mk_sample(1'b1, 32'd0, 24'd1, 32'd0));
    pending_samples.push_back(mk_sample(1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0));
    wait_idle();
    gen_last_err = last_error;

    // Random phases, each under its own settings; every fourth runs without gaps.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          kp_w = 32'h0000_0400; kd_w = 32'h0000_0010; ht_w = 32'd5898240;
        end
        1: begin
          kp_w = 32'h8000_0000; kd_w = 32'h7FFF_FFFF; ht_w = 32'h7FFF_FFFF;
        end
        2: begin
          kp_w = 32'h7FFF_FFFF; kd_w = 32'h8000_0000; ht_w = 32'h0000_0000;
        end
        3: begin
          kp_w = small_signed(4096); kd_w = -(32'($urandom_range(1, 64))); ht_w = 32'd100;
        end
        4: begin
          kp_w = 32'hFFFF_FFFF; kd_w = 32'h0000_0001; ht_w = 32'hFFFF_FFFF;
        end
        5: begin
          kp_w = $urandom(); kd_w = $urandom(); ht_w = $urandom();
        end
        6: begin
          kp_w = 32'd0; kd_w = 32'd0; ht_w = 32'(apdc_pkg::HALF_TURN_RESET);
        end
        default: begin
          kp_w = small_signed(2048); kd_w = small_signed(32);
          ht_w = $urandom_range(1, 32'h00FF_FFFF);
        end
      endcase
      quiet_gaps = ((ph % 4) == 3);
      write_reg(apdc_pkg::CFG_KP_GAIN, kp_w);
      write_reg(apdc_pkg::CFG_KD_GAIN, kd_w);
      write_reg(apdc_pkg::CFG_HALF_TURN, ht_w);
      repeat (PHASE_LEN) pending_samples.push_back(rand_sample());
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (owed_results.size() != 0)
        $display("%0t %0d results never arrived", $time, owed_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/apdc_pkg.sv
hw/rtl/apdc_if.sv
hw/rtl/apdc_mul.sv
hw/rtl/apdc_div.sv
hw/rtl/angular_pd_controller.sv
test/tb_angular_pd_controller.sv
